@@ hw/rtl/tcgw_pkg.sv @@
// ---------------------------------------------------------------------------
// tcgw_pkg: shared types and constants for the text console grid writer
// Command codes, character codes, decoded operation record and the status
// groups passed between the front end, the queue and the back end.
// ---------------------------------------------------------------------------
package tcgw_pkg;

	// field widths fixed by the interface
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned RSEL_W  = 5;
	localparam int unsigned COL_W   = 8;  // column values, column count
	localparam int unsigned ROW_W   = 6;  // row values, row count (6-bit register)
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SETCUR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 1'b1;

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'd0;
	localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_LF       = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_CR       = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'd32;

	// register reset values
	localparam logic [COL_W-1:0] TEXT_COLUMNS_RST = 8'd80;
	localparam logic [ROW_W-1:0] TEXT_ROWS_RST    = 6'd25;

	// decoded operation kinds
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_LF,
		OP_CR,
		OP_CLEAR,
		OP_SETCUR,
		OP_READ
	} op_kind_t;

	// one decoded command with the grid size in force when it was taken
	typedef struct packed {
		op_kind_t          kind;
		logic [CHAR_W-1:0] ch;        // already upcased
		logic [ROW_W-1:0]  row;       // clamped for set cursor, raw for read
		logic [COL_W-1:0]  col;
		logic              in_range;  // read address inside the grid
		logic [ROW_W-1:0]  rows;      // effective row count, 1..
		logic [COL_W-1:0]  cols;      // effective column count, 1..
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic init_busy;  // power-on clearing pass running
		logic out_load;   // result register loaded this cycle
	} bk_status_t;

endpackage

@@ hw/rtl/tcgw_front.sv @@
// ---------------------------------------------------------------------------
// tcgw_front: command intake and decode
// Holds the size registers, accepts commands and turns each one into an
// operation record (case folding, clamping, range check) for the queue.
// ---------------------------------------------------------------------------
module tcgw_front #(
	parameter int unsigned MAX_COLS = 128,
	parameter int unsigned MAX_ROWS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [tcgw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcgw_pkg::CFG_DATA_W-1:0] cfg_data,
	// command channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tcgw_pkg::CMD_W-1:0]      cmd,
	input  logic [tcgw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcgw_pkg::RSEL_W-1:0]     row_sel,
	input  logic [tcgw_pkg::COL_W-1:0]      col_sel,
	// to queue
	input  tcgw_pkg::q_status_t             q_stat,
	input  tcgw_pkg::bk_status_t            bk_stat,
	output logic                           push,
	output tcgw_pkg::op_t                   op
);
	import tcgw_pkg::*;

	logic [COL_W-1:0] text_columns_q;
	logic [ROW_W-1:0] text_rows_q;
	logic [COL_W-1:0] cols_eff;
	logic [ROW_W-1:0] rows_eff;
	logic [ROW_W-1:0] rsel_ext;
	logic [CHAR_W-1:0] ch_up;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_columns_q <= TEXT_COLUMNS_RST;
			text_rows_q    <= TEXT_ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEXT_COLUMNS: text_columns_q <= cfg_data;
				REG_TEXT_ROWS:    text_rows_q    <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size: zero acts as one, oversize saturates
	always_comb begin
		if (text_columns_q == '0)
			cols_eff = COL_W'(1);
		else if (int'(text_columns_q) > MAX_COLS)
			cols_eff = COL_W'(MAX_COLS);
		else
			cols_eff = text_columns_q;
		if (text_rows_q == '0)
			rows_eff = ROW_W'(1);
		else if (int'(text_rows_q) > MAX_ROWS)
			rows_eff = ROW_W'(MAX_ROWS);
		else
			rows_eff = text_rows_q;
	end

	assign rsel_ext = ROW_W'(row_sel);
	assign ch_up = (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) ?
		char_code - CASE_OFFSET : char_code;

	// handshake: hold off while the queue is full or the grid is initializing
	assign in_stall = q_stat.full | bk_stat.init_busy;
	assign push     = in_valid & ~in_stall;

	// decode
	always_comb begin
		op          = '0;
		op.kind     = OP_NOP;
		op.ch       = ch_up;
		op.rows     = rows_eff;
		op.cols     = cols_eff;
		op.row      = rsel_ext;
		op.col      = col_sel;
		op.in_range = (rsel_ext < rows_eff) && (col_sel < cols_eff);
		unique case (cmd)
			CMD_PUT: begin
				if (char_code == CHAR_NUL)
					op.kind = OP_NOP;
				else if (ch_up == CHAR_LF)
					op.kind = OP_LF;
				else if (ch_up == CHAR_CR)
					op.kind = OP_CR;
				else
					op.kind = OP_PUT;
			end
			CMD_CLEAR: op.kind = OP_CLEAR;
			CMD_SETCUR: begin
				op.kind = OP_SETCUR;
				op.row  = (rsel_ext >= rows_eff) ? rows_eff - ROW_W'(1) : rsel_ext;
				op.col  = (col_sel >= cols_eff) ? cols_eff - COL_W'(1) : col_sel;
			end
			CMD_READ: op.kind = OP_READ;
			default: op.kind = OP_NOP;
		endcase
	end

endmodule

@@ hw/rtl/tcgw_queue.sv @@
// ---------------------------------------------------------------------------
// tcgw_queue: two-entry operation queue
// Decouples the intake from the grid engine so either side can stall.
// ---------------------------------------------------------------------------
module tcgw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tcgw_pkg::op_t        push_op,
	input  logic                pop,
	output tcgw_pkg::op_t        head,
	output tcgw_pkg::q_status_t  q_stat
);
	import tcgw_pkg::*;

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.full  = count_q[1];
	assign q_stat.empty = (count_q == 2'd0);

endmodule

@@ hw/rtl/tcgw_back.sv @@
// ---------------------------------------------------------------------------
// tcgw_back: grid engine
// Owns the cell memory and cursor, runs puts, scrolls, clears and reads,
// and holds the result register toward the output channel.
// ---------------------------------------------------------------------------
module tcgw_back #(
	parameter int unsigned MAX_COLS = 128,
	parameter int unsigned MAX_ROWS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// from queue
	input  tcgw_pkg::op_t                 head,
	input  tcgw_pkg::q_status_t           q_stat,
	output logic                         pop,
	output tcgw_pkg::bk_status_t          bk_stat,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tcgw_pkg::CHAR_W-1:0]   cell_char,
	output logic [tcgw_pkg::COL_W-1:0]    cursor_col_out,
	output logic [tcgw_pkg::RSEL_W-1:0]   cursor_row_out,
	output logic                         scrolled
);
	import tcgw_pkg::*;

	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned AW    = RW + CW;
	localparam int unsigned DEPTH = 1 << AW;

	typedef enum logic [7:0] {
		ST_INIT     = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_CLEAR    = 8'b0000_0100,
		ST_SCR_RD   = 8'b0000_1000,
		ST_SCR_WR   = 8'b0001_0000,
		ST_SCR_FILL = 8'b0010_0000,
		ST_FINISH   = 8'b0100_0000,
		ST_READ     = 8'b1000_0000
	} bk_state_t;

	bk_state_t state_q, state_d;
	logic [COL_W-1:0] cur_col_q, cur_col_d;
	logic [ROW_W-1:0] cur_row_q, cur_row_d;
	logic [ROW_W-1:0] scr_row_q, scr_row_d;
	logic [COL_W-1:0] scr_col_q, scr_col_d;
	logic [AW-1:0]    addr_q, addr_d;
	op_t              op_q, op_d;

	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [CHAR_W-1:0] mem_wdata;

	logic              out_valid_q;
	logic [CHAR_W-1:0] cell_q;
	logic [COL_W-1:0]  ocol_q;
	logic [ROW_W-1:0]  orow_q;
	logic              oscr_q;

	logic              out_free;
	logic              out_load;
	logic [CHAR_W-1:0] res_cell;
	logic              res_scr;
	logic              start_scroll;
	logic [ROW_W-1:0]  row_sat;
	logic              last_row;
	logic              wrap;
	logic [ROW_W-1:0]  last_idx;

	function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return {RW'(r), CW'(c)};
	endfunction

	// put context for the head item
	assign row_sat  = (cur_row_q >= head.rows) ? head.rows - ROW_W'(1) : cur_row_q;
	assign last_row = (row_sat == head.rows - ROW_W'(1));
	assign wrap     = (cur_col_q >= head.cols);
	assign last_idx = op_q.rows - ROW_W'(1);

	assign out_free = ~out_valid_q | ~out_stall;

	// sequencer
	always_comb begin
		state_d      = state_q;
		cur_col_d    = cur_col_q;
		cur_row_d    = cur_row_q;
		scr_row_d    = scr_row_q;
		scr_col_d    = scr_col_q;
		addr_d       = addr_q;
		op_d         = op_q;
		pop          = 1'b0;
		out_load     = 1'b0;
		res_cell     = CHAR_NUL;
		res_scr      = 1'b0;
		start_scroll = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = addr_q;
		mem_wdata    = CHAR_SPACE;
		mem_raddr    = cell_addr(head.row, head.col);
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				addr_d = addr_q + AW'(1);
				if (addr_q == '1)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_stat.empty && out_free) begin
					pop  = 1'b1;
					op_d = head;
					unique case (head.kind)
						OP_NOP: out_load = 1'b1;
						OP_CR: begin
							cur_row_d = row_sat;
							cur_col_d = '0;
							out_load  = 1'b1;
						end
						OP_LF: begin
							cur_col_d = '0;
							if (last_row) begin
								cur_row_d    = row_sat;
								start_scroll = 1'b1;
							end else begin
								cur_row_d = row_sat + ROW_W'(1);
								out_load  = 1'b1;
							end
						end
						OP_PUT: begin
							if (wrap) begin
								cur_col_d = '0;
								if (last_row) begin
									cur_row_d    = row_sat;
									start_scroll = 1'b1;
								end else begin
									cur_row_d = row_sat + ROW_W'(1);
									mem_we    = 1'b1;
									mem_waddr = cell_addr(row_sat + ROW_W'(1), '0);
									mem_wdata = head.ch;
									cur_col_d = COL_W'(1);
									out_load  = 1'b1;
								end
							end else begin
								cur_row_d = row_sat;
								mem_we    = 1'b1;
								mem_waddr = cell_addr(row_sat, cur_col_q);
								mem_wdata = head.ch;
								cur_col_d = cur_col_q + COL_W'(1);
								out_load  = 1'b1;
							end
						end
						OP_CLEAR: begin
							addr_d  = '0;
							state_d = ST_CLEAR;
						end
						OP_SETCUR: begin
							cur_row_d = head.row;
							cur_col_d = head.col;
							out_load  = 1'b1;
						end
						OP_READ: state_d = ST_READ;
						default: out_load = 1'b1;
					endcase
					// scroll: copy rows up, then blank the bottom row
					if (start_scroll) begin
						scr_row_d = ROW_W'(1);
						scr_col_d = '0;
						state_d   = (head.rows == ROW_W'(1)) ? ST_SCR_FILL : ST_SCR_RD;
					end
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				addr_d = addr_q + AW'(1);
				if (addr_q == '1) begin
					cur_col_d = '0;
					cur_row_d = '0;
					out_load  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_SCR_RD: begin
				mem_raddr = cell_addr(scr_row_q, scr_col_q);
				state_d   = ST_SCR_WR;
			end
			ST_SCR_WR: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(scr_row_q - ROW_W'(1), scr_col_q);
				mem_wdata = rd_q;
				if (scr_col_q == op_q.cols - COL_W'(1)) begin
					scr_col_d = '0;
					if (scr_row_q == last_idx) begin
						state_d = ST_SCR_FILL;
					end else begin
						scr_row_d = scr_row_q + ROW_W'(1);
						state_d   = ST_SCR_RD;
					end
				end else begin
					scr_col_d = scr_col_q + COL_W'(1);
					state_d   = ST_SCR_RD;
				end
			end
			ST_SCR_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(last_idx, scr_col_q);
				if (scr_col_q == op_q.cols - COL_W'(1))
					state_d = ST_FINISH;
				else
					scr_col_d = scr_col_q + COL_W'(1);
			end
			ST_FINISH: begin
				// a wrapped put lands at the start of the fresh bottom row
				if (op_q.kind == OP_PUT) begin
					mem_we    = 1'b1;
					mem_waddr = cell_addr(last_idx, '0);
					mem_wdata = op_q.ch;
					cur_col_d = COL_W'(1);
				end
				res_scr  = 1'b1;
				out_load = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_READ: begin
				res_cell = op_q.in_range ? rd_q : CHAR_SPACE;
				out_load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			addr_q      <= '0;
			scr_row_q   <= '0;
			scr_col_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cur_col_q   <= cur_col_d;
			cur_row_q   <= cur_row_d;
			addr_q      <= addr_d;
			scr_row_q   <= scr_row_d;
			scr_col_q   <= scr_col_d;
			out_valid_q <= out_load | (out_valid_q & out_stall);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		op_q <= op_d;
		if (out_load) begin
			cell_q <= res_cell;
			ocol_q <= cur_col_d;
			orow_q <= cur_row_d;
			oscr_q <= res_scr;
		end
	end

	// cell memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	assign out_valid      = out_valid_q;
	assign cell_char      = cell_q;
	assign cursor_col_out = ocol_q;
	assign cursor_row_out = orow_q[RSEL_W-1:0];
	assign scrolled       = oscr_q;

	assign bk_stat.init_busy = (state_q == ST_INIT);
	assign bk_stat.out_load  = out_load;

endmodule

@@ hw/rtl/text_console_grid_writer_unit.sv @@
// Put, CR, LF and set cursor load the result register as they leave the queue;
// a read first passes ST_READ for the registered memory read. A scroll copies
// each cell up a row, then blanks the bottom row; clear walks the whole cell memory.
// Throughput: one plain command per cycle while the result channel is not stalled.
// Reset: cursor 0,0, sizes 80x25; a clearing pass over the whole cell memory
// blanks it after reset, during which no command is accepted.
// ---------------------------------------------------------------------------
// text_console_grid_writer_unit: character-cell text console
// Intake/decode front end, two-entry queue and grid engine with cursor,
// lazy wrap, scroll, clear and cell read.
// ---------------------------------------------------------------------------
module text_console_grid_writer_unit #(
	parameter int unsigned MAX_COLS = 128,
	parameter int unsigned MAX_ROWS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tcgw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcgw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tcgw_pkg::CMD_W-1:0]      cmd,
	input  logic [tcgw_pkg::CHAR_W-1:0]     char_code,
	input  logic [tcgw_pkg::RSEL_W-1:0]     row_sel,
	input  logic [tcgw_pkg::COL_W-1:0]      col_sel,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tcgw_pkg::CHAR_W-1:0]     cell_char,
	output logic [tcgw_pkg::COL_W-1:0]      cursor_col_out,
	output logic [tcgw_pkg::RSEL_W-1:0]     cursor_row_out,
	output logic                           scrolled
);
	import tcgw_pkg::*;

	q_status_t  q_stat;
	bk_status_t bk_stat;
	logic       push;
	logic       pop;
	op_t        push_op;
	op_t        head;

	tcgw_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.char_code (char_code),
		.row_sel   (row_sel),
		.col_sel   (col_sel),
		.q_stat    (q_stat),
		.bk_stat   (bk_stat),
		.push      (push),
		.op        (push_op)
	);

	tcgw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	tcgw_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_stat         (q_stat),
		.pop            (pop),
		.bk_stat        (bk_stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cell_char      (cell_char),
		.cursor_col_out (cursor_col_out),
		.cursor_row_out (cursor_row_out),
		.scrolled       (scrolled)
	);

	// checks
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.out_load |-> (!out_valid || !out_stall))
		else $error("result register loaded while holding an untaken beat");

	a_no_result_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.init_busy |-> !out_valid)
		else $error("result beat during power-on clearing pass");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !q_stat.empty)
		else $error("accepted beat missing from queue");

endmodule
